### design/srb_pkg.sv
package srb_pkg;

  localparam int RING_SLOTS_DEF   = 8;
  localparam int SLOT_SAMPLES_DEF = 32;
  localparam int SAFETY_GAP       = 2;
  localparam int WORD_W           = 32;
  localparam int COUNT_W          = 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_COMMIT    = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_SAMPLE    = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] sample_word;
    logic              sample_last;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [WORD_W-1:0]  out_sample;
    logic               out_last;
    logic [COUNT_W-1:0] readable_slots;
    logic [COUNT_W-1:0] writable_slots;
    logic [WORD_W-1:0]  overflow_total;
    logic [WORD_W-1:0]  underflow_total;
  } out_word_t;

endpackage

### design/srb_chan_if.sv
interface srb_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/srb_mem.sv
module srb_mem #(
  parameter int DEPTH = srb_pkg::RING_SLOTS_DEF * srb_pkg::SLOT_SAMPLES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [srb_pkg::WORD_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [srb_pkg::WORD_W-1:0] rdata
);

  logic [srb_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low, so a stalled word stays put
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/slot_ring_buffer_with_gap_unit.sv
// channel | dir | payload                                   | accepted when
// cmd     | in  | command, sample_word, sample_last         | valid & ready
// res     | out | status, out_sample, out_last, slot counts | valid & ready
//
// A plain write sample is stored as it is taken; one that ends a short slot adds a zero-write
// per unfilled position (SLOT_SAMPLES - samples given) through the single RAM write port.
// Commit and refusal results are loaded in state S_RESP, after their word and any padding.
// A read streams SLOT_SAMPLES words one per unstalled cycle from the registered RAM read port.
// Input stays closed until the result of the last word taken is in the output register.
// Sync reset clears slot marks, pointers and counters; RAM is untouched. Stalls hold results.
module slot_ring_buffer_with_gap_unit #(
  parameter int RING_SLOTS   = srb_pkg::RING_SLOTS_DEF,
  parameter int SLOT_SAMPLES = srb_pkg::SLOT_SAMPLES_DEF
) (
  input logic      clk,
  input logic      rst,
  srb_chan_if.sink   cmd,
  srb_chan_if.source res
);

  localparam int DEPTH = RING_SLOTS * SLOT_SAMPLES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(RING_SLOTS);
  localparam int FW    = $clog2(SLOT_SAMPLES + 1);
  localparam int LIMIT = RING_SLOTS - srb_pkg::SAFETY_GAP;
  localparam logic [FW-1:0] LAST_POS = FW'(SLOT_SAMPLES - 1);
  localparam logic [FW-1:0] FULL_POS = FW'(SLOT_SAMPLES);

  typedef enum logic [1:0] {S_IDLE, S_PAD, S_READ, S_RESP} state_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(RING_SLOTS - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  function automatic logic [PW-1:0] lead_of(input logic [PW-1:0] w, input logic [PW-1:0] r);
    logic [PW:0] diff;
    diff = (w >= r) ? ({1'b0, w} - {1'b0, r})
                    : ({1'b0, w} + (PW+1)'(RING_SLOTS) - {1'b0, r});
    return diff[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] s, input logic [FW-1:0] p);
    return AW'(AW'(s) * AW'(SLOT_SAMPLES)) + AW'(p);
  endfunction

  state_t                     state;
  logic [RING_SLOTS-1:0]      slot_taken;
  logic [PW-1:0]              wp;
  logic [PW-1:0]              rp;
  logic [FW-1:0]              fill;
  logic                       rejected;
  logic [srb_pkg::WORD_W-1:0] ovf_count;
  logic [srb_pkg::WORD_W-1:0] unf_count;
  logic                       out_valid;
  srb_pkg::out_word_t         out_word;
  srb_pkg::status_t           pend_status;
  logic [PW-1:0]              pad_slot;
  logic [FW-1:0]              pad_pos;
  logic [PW-1:0]              rd_slot;
  logic [FW-1:0]              rd_pos;

  srb_pkg::in_word_t          in_w;
  logic                       accept;
  logic                       is_read;
  logic [PW-1:0]              lead_now;
  logic                       wr_refuse;
  logic                       rd_refuse;
  logic                       wr_start_refused;
  logic                       wr_store;
  logic [FW-1:0]              fill_eff;
  logic                       out_free;
  logic                       out_load;
  logic                       rd_advance;
  logic [FW-1:0]              rd_pos_inc;
  logic [srb_pkg::COUNT_W-1:0] readable;
  logic [srb_pkg::COUNT_W-1:0] writable;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [srb_pkg::WORD_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [srb_pkg::WORD_W-1:0] mem_rdata;

  assign in_w      = cmd.payload;
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign is_read   = (in_w.command == srb_pkg::CMD_READ);

  assign lead_now  = lead_of(wp, rp);
  assign wr_refuse = slot_taken[wp] || (int'(lead_now) >= LIMIT);
  assign rd_refuse = (int'(lead_now) < srb_pkg::SAFETY_GAP) || !slot_taken[rp];
  assign wr_start_refused = (fill == '0) && wr_refuse;
  assign wr_store  = accept && !is_read && !rejected && !wr_start_refused && (fill < FULL_POS);
  assign fill_eff  = (fill < FULL_POS) ? FW'(fill + 1'b1) : fill;

  assign out_free   = !out_valid || res.ready;
  assign out_load   = ((state == S_READ) || (state == S_RESP)) && out_free;
  assign rd_advance = (state == S_READ) && out_free && (rd_pos != LAST_POS);
  assign rd_pos_inc = FW'(rd_pos + 1'b1);

  // counts seen by a result come from the already-updated pointers
  assign readable = srb_pkg::COUNT_W'(lead_now);
  assign writable = (int'(lead_now) >= LIMIT) ? '0
                  : srb_pkg::COUNT_W'(srb_pkg::COUNT_W'(LIMIT) - readable);

  always_comb begin
    mem_we    = wr_store || (state == S_PAD);
    mem_waddr = (state == S_PAD) ? addr_of(pad_slot, pad_pos) : addr_of(wp, fill);
    mem_wdata = (state == S_PAD) ? '0 : in_w.sample_word;
    mem_re    = (accept && is_read && !rd_refuse) || rd_advance;
    mem_raddr = (state == S_READ) ? addr_of(rd_slot, rd_pos_inc) : addr_of(rp, '0);
  end

  srb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slot_taken   <= '0;
      wp           <= '0;
      rp           <= '0;
      fill         <= '0;
      rejected     <= 1'b0;
      ovf_count    <= '0;
      unf_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !res.ready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_read) begin
              if (rd_refuse) begin
                unf_count   <= unf_count + 1'b1;
                pend_status <= srb_pkg::ST_UNDERFLOW;
                state       <= S_RESP;
              end else begin
                slot_taken[rp] <= 1'b0;
                rp      <= ptr_inc(rp);
                rd_slot <= rp;
                rd_pos  <= '0;
                state   <= S_READ;
              end
            end else if (rejected) begin
              // tail of a refused slot write: drop up to the last word
              if (in_w.sample_last) begin
                rejected <= 1'b0;
              end
            end else if (wr_start_refused) begin
              ovf_count   <= ovf_count + 1'b1;
              rejected    <= !in_w.sample_last;
              pend_status <= srb_pkg::ST_OVERFLOW;
              state       <= S_RESP;
            end else if (!in_w.sample_last) begin
              fill <= fill_eff;
            end else begin
              // commit now; padding of the short slot follows
              slot_taken[wp] <= 1'b1;
              wp          <= ptr_inc(wp);
              fill        <= '0;
              pad_slot    <= wp;
              pad_pos     <= fill_eff;
              pend_status <= srb_pkg::ST_COMMIT;
              state       <= (fill_eff == FULL_POS) ? S_RESP : S_PAD;
            end
          end
        end
        S_PAD: begin
          if (pad_pos == LAST_POS) begin
            state <= S_RESP;
          end else begin
            pad_pos <= FW'(pad_pos + 1'b1);
          end
        end
        S_READ: begin
          if (out_free) begin
            out_word  <= '{status:          srb_pkg::ST_SAMPLE,
                           out_sample:      mem_rdata,
                           out_last:        (rd_pos == LAST_POS),
                           readable_slots:  readable,
                           writable_slots:  writable,
                           overflow_total:  ovf_count,
                           underflow_total: unf_count};
            if (rd_pos == LAST_POS) begin
              state <= S_IDLE;
            end else begin
              rd_pos <= rd_pos_inc;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_word  <= '{status:          pend_status,
                           out_sample:      '0,
                           out_last:        1'b1,
                           readable_slots:  readable,
                           writable_slots:  writable,
                           overflow_total:  ovf_count,
                           underflow_total: unf_count};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid   = out_valid;
  assign res.payload = out_word;

`ifndef ASSERT_OFF
  // the two-slot gap keeps the writer from lapping the reader
  a_gap_kept: assert property (@(posedge clk) disable iff (rst)
    int'(lead_now) <= LIMIT)
    else $error("writer lead beyond ring limit");

  a_write_slot_free: assert property (@(posedge clk) disable iff (rst)
    !slot_taken[wp])
    else $error("slot under the write pointer still holds data");

  a_read_starts: assert property (@(posedge clk) disable iff (rst)
    accept && is_read && !rd_refuse |=> state == S_READ && rp == ptr_inc($past(rp)))
    else $error("granted read did not start streaming");

  a_stream_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.ready && state == S_READ |=> out_valid && $stable(mem_rdata))
    else $error("read data lost while output stalled");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int NS           = srb_pkg::RING_SLOTS_DEF;
  localparam int SS           = srb_pkg::SLOT_SAMPLES_DEF;
  localparam int GAP          = srb_pkg::SAFETY_GAP;
  localparam int WW           = srb_pkg::WORD_W;
  localparam int CW           = srb_pkg::COUNT_W;
  localparam int HOLD_AT      = 80;    // items taken before the long output stall
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 300;   // items taken: no idling on either side
  localparam int CALM_TO      = 380;
  localparam int WATCHDOG     = 2000;
  localparam int TAIL_CYCLES  = 2 * SS;

  logic clk;
  logic rst;

  srb_chan_if #(.payload_t(srb_pkg::in_word_t))  cmd ();
  srb_chan_if #(.payload_t(srb_pkg::out_word_t)) res ();

  slot_ring_buffer_with_gap_unit #(
    .RING_SLOTS   (NS),
    .SLOT_SAMPLES (SS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ring state as the block should hold it
  logic [WW-1:0]     slot_data [NS*SS];
  bit                slot_full [NS];
  int unsigned       wr_slot;
  int unsigned       rd_slot;
  int unsigned       fill_cnt;
  bit                dropping;
  logic [WW-1:0]     overflow_cnt = '0;
  logic [WW-1:0]     underflow_cnt = '0;

  srb_pkg::in_word_t  pending_words [$];
  srb_pkg::out_word_t expected_words [$];
  srb_pkg::out_word_t want_word;
  int        items_taken;
  int        fail_count;
  int        hold_left;
  bit        hold_done;
  int        quiet_cycles;
  wire       calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

  function automatic int unsigned writer_lead();
    return (wr_slot + NS - rd_slot) % NS;
  endfunction

  function automatic void expect_word(srb_pkg::status_t st, logic [WW-1:0] smp, logic lst);
    srb_pkg::out_word_t r;
    int unsigned        lead;
    lead               = writer_lead();
    r.status           = st;
    r.out_sample       = smp;
    r.out_last         = lst;
    r.readable_slots   = lead[CW-1:0];
    r.writable_slots   = (lead >= NS - GAP) ? '0 : CW'(NS - GAP - lead);
    r.overflow_total   = overflow_cnt;
    r.underflow_total  = underflow_cnt;
    expected_words.push_back(r);
  endfunction

  function automatic void ring_accept(srb_pkg::in_word_t w);
    int unsigned base;
    if (w.command == srb_pkg::CMD_READ) begin
      if (writer_lead() < GAP || !slot_full[rd_slot]) begin
        underflow_cnt++;
        expect_word(srb_pkg::ST_UNDERFLOW, '0, 1'b1);
      end else begin
        base = rd_slot * SS;
        slot_full[rd_slot] = 1'b0;
        rd_slot = (rd_slot + 1) % NS;
        for (int i = 0; i < SS; i++)
          expect_word(srb_pkg::ST_SAMPLE, slot_data[base + i], i == SS - 1);
      end
      return;
    end
    base = wr_slot * SS;
    if (dropping) begin
      if (w.sample_last) dropping = 1'b0;
      return;
    end
    // admission is decided on the first word of a slot only
    if (fill_cnt == 0 && (slot_full[wr_slot] || writer_lead() >= NS - GAP)) begin
      overflow_cnt++;
      dropping = !w.sample_last;
      expect_word(srb_pkg::ST_OVERFLOW, '0, 1'b1);
      return;
    end
    if (fill_cnt < SS) begin
      slot_data[base + fill_cnt] = w.sample_word;
      fill_cnt++;
    end
    if (!w.sample_last) return;
    while (fill_cnt < SS) begin
      slot_data[base + fill_cnt] = '0;
      fill_cnt++;
    end
    slot_full[wr_slot] = 1'b1;
    wr_slot = (wr_slot + 1) % NS;
    fill_cnt = 0;
    expect_word(srb_pkg::ST_COMMIT, '0, 1'b1);
  endfunction

  function automatic void check_field(string what, logic [WW-1:0] want,
                                      logic [WW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid   <= 1'b0;
      cmd.payload <= '0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        ring_accept(cmd.payload);
        items_taken++;
      end
      if (!cmd.valid || cmd.ready) begin
        if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
          cmd.valid   <= 1'b1;
          cmd.payload <= pending_words.pop_front();
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // long output stall, once, while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %p", $time, res.payload);
          fail_count++;
        end else begin
          want_word = expected_words.pop_front();
          check_field("status", WW'(want_word.status), WW'(res.payload.status));
          check_field("out_sample", want_word.out_sample, res.payload.out_sample);
          check_field("out_last", WW'(want_word.out_last), WW'(res.payload.out_last));
          check_field("readable_slots", WW'(want_word.readable_slots),
                      WW'(res.payload.readable_slots));
          check_field("writable_slots", WW'(want_word.writable_slots),
                      WW'(res.payload.writable_slots));
          check_field("overflow_total", want_word.overflow_total,
                      res.payload.overflow_total);
          check_field("underflow_total", want_word.underflow_total,
                      res.payload.underflow_total);
        end
      end
      res.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [WW-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  function automatic void queue_raw(logic c, logic [WW-1:0] smp, logic lst);
    srb_pkg::in_word_t w;
    w.command     = c;
    w.sample_word = smp;
    w.sample_last = lst;
    pending_words.push_back(w);
  endfunction

  // read fields other than the command are don't-care, so fill them randomly
  function automatic void queue_read();
    queue_raw(srb_pkg::CMD_READ, $urandom, 1'($urandom_range(1)));
  endfunction

  function automatic void queue_write(int len, bit mid_read);
    int split;
    split = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      if (mid_read && i == split && i != 0) queue_read();
      queue_raw(srb_pkg::CMD_WRITE, rand_word(), i == len - 1);
    end
  endfunction

  function automatic int random_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom_range(SS + 4, SS - 2);
    if (pick < 18) return SS;
    return $urandom_range(6, 1);
  endfunction

  function automatic void queue_random(int n_items);
    int unsigned pick;
    int          target;
    target = pending_words.size() + n_items;
    while (pending_words.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 55)
        queue_write(random_len(), $urandom_range(99) < 15);
      else if (pick < 90)
        queue_read();
      else
        queue_raw(1'($urandom_range(1)), rand_word(), 1'($urandom_range(1)));
    end
  endfunction

  task automatic wait_drained();
    do
      @(posedge clk);
    while (pending_words.size() != 0 || cmd.valid || expected_words.size() != 0);
  endtask

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_read();                                  // empty ring
    queue_raw(srb_pkg::CMD_WRITE, '1, 1'b1);       // single word, rest padded
    queue_read();                                  // writer only one slot ahead
    queue_raw(srb_pkg::CMD_WRITE, '0, 1'b0);
    queue_raw(srb_pkg::CMD_WRITE, '1, 1'b1);
    queue_raw(srb_pkg::CMD_WRITE, 32'h1234_5678, 1'b0);  // read lands inside a write
    queue_read();
    queue_raw(srb_pkg::CMD_WRITE, 32'h8765_4321, 1'b1);
    repeat (4) queue_raw(srb_pkg::CMD_WRITE, $urandom, 1'b1);  // up to the gap limit
    queue_raw(srb_pkg::CMD_WRITE, $urandom, 1'b1); // refused, single word
    queue_raw(srb_pkg::CMD_WRITE, $urandom, 1'b0); // refused, tail dropped
    queue_raw(srb_pkg::CMD_WRITE, $urandom, 1'b0);
    queue_raw(srb_pkg::CMD_WRITE, $urandom, 1'b1);
    queue_read();
    queue_read();
    wait_drained();

    queue_write(SS + 3, 1'b0);                     // overlong write
    queue_random(180);
    wait_drained();
    queue_random(200);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
